>>> sv/scrs_pkg.sv
// scrs_pkg: shared types and constants for the stripe/chunk range splitter.
// Used by every module of the block; no dependencies.
package scrs_pkg;

  localparam int USER_W  = 32;
  localparam int ADDR_W  = 48;
  localparam int LEN_W   = 32;
  localparam int CHUNK_W = 32;
  localparam int DCNT_W  = 5;
  localparam int CIDX_W  = 4;
  localparam int IN_W    = 112;
  localparam int OUT_W   = 168;
  localparam int PADDR_W = 4;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_CHUNK = 2'd1;
  localparam logic [1:0] REG_DCNT  = 2'd2;

  typedef struct packed {
    logic                rep;
    logic [CHUNK_W-1:0]  csize;
    logic [DCNT_W-1:0]   dcnt;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel;
    logic take_off;
    logic take_stripe;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic rep;
    logic div_done;
    logic last;
    logic out_free;
  } stat_t;

endpackage

>>> sv/scrs_div.sv
// scrs_div: restoring divider, one quotient bit per cycle.
// Depends on scrs_pkg.
module scrs_div #(
  parameter int DW = 48,
  parameter int VW = scrs_pkg::CHUNK_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] count;
  logic [VW-1:0] dvs;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, quot[DW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CW'(1);
        if (count == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem  <= VW'(trial - {1'b0, dvs});
        quot <= {quot[DW-2:0], 1'b1};
      end else begin
        rem  <= trial[VW-1:0];
        quot <= {quot[DW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/scrs_dp.sv
// scrs_dp: splitter datapath - request capture, divider, piece walk, output register.
// Depends on scrs_pkg and scrs_div.
module scrs_dp #(
  parameter int MAX_PIECES  = 64,
  parameter int OFFSET_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  scrs_pkg::cmd_t                cmd,
  output scrs_pkg::stat_t               stat,
  input  scrs_pkg::cfg_t                cfg,
  input  logic [scrs_pkg::USER_W-1:0]   in_user,
  input  logic [scrs_pkg::ADDR_W-1:0]   in_start,
  input  logic [scrs_pkg::LEN_W-1:0]    in_len,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [scrs_pkg::USER_W-1:0]   piece_user,
  output logic [scrs_pkg::ADDR_W-1:0]   stripe_index,
  output logic [scrs_pkg::CIDX_W-1:0]   chunk_index,
  output logic [scrs_pkg::ADDR_W-1:0]   piece_offset,
  output logic [scrs_pkg::LEN_W-1:0]    piece_length,
  output logic                          last_piece,
  output logic                          truncated
);

  localparam int AW  = (OFFSET_BITS < scrs_pkg::ADDR_W) ? OFFSET_BITS : scrs_pkg::ADDR_W;
  localparam int PCW = $clog2(MAX_PIECES + 1);

  logic [scrs_pkg::USER_W-1:0]  user;
  logic [AW-1:0]                start;
  logic                         rep;
  logic [scrs_pkg::LEN_W-1:0]   bytes_left;
  logic [scrs_pkg::CHUNK_W-1:0] cur_in_offset;
  logic [scrs_pkg::CIDX_W-1:0]  cur_chunk;
  logic [AW-1:0]                cur_stripe;
  logic [PCW-1:0]               pieces_sent;

  logic [AW-1:0]                div_dividend;
  logic [scrs_pkg::CHUNK_W-1:0] div_divisor;
  logic                         div_done;
  logic [AW-1:0]                div_quot;
  logic [scrs_pkg::CHUNK_W-1:0] div_rem;

  logic [scrs_pkg::CHUNK_W-1:0] room;
  logic [scrs_pkg::LEN_W-1:0]   plen;
  logic [scrs_pkg::LEN_W-1:0]   bytes_left_next;
  logic                         at_limit;
  logic                         walk_last;
  logic [scrs_pkg::DCNT_W-1:0]  chunk_inc;

  assign div_dividend = cmd.div_sel ? div_quot : in_start[AW-1:0];
  assign div_divisor  = cmd.div_sel ? scrs_pkg::CHUNK_W'(cfg.dcnt) : cfg.csize;

  scrs_div #(
    .DW (AW),
    .VW (scrs_pkg::CHUNK_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign room            = cfg.csize - cur_in_offset;
  assign plen            = (bytes_left < room) ? bytes_left : room;
  assign bytes_left_next = bytes_left - plen;
  assign at_limit        = pieces_sent == PCW'(MAX_PIECES - 1);
  assign walk_last       = (bytes_left_next == '0) || at_limit;
  assign chunk_inc       = {1'b0, cur_chunk} + scrs_pkg::DCNT_W'(1);

  assign stat.len_zero = in_len == '0;
  assign stat.rep      = cfg.rep;
  assign stat.div_done = div_done;
  assign stat.last     = rep || walk_last;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      bytes_left    <= '0;
      cur_in_offset <= '0;
      cur_chunk     <= '0;
      cur_stripe    <= '0;
      pieces_sent   <= '0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        bytes_left  <= in_len;
        pieces_sent <= '0;
      end
      if (cmd.take_off) begin
        cur_in_offset <= div_rem;
      end
      if (cmd.take_stripe) begin
        cur_stripe <= div_quot;
        cur_chunk  <= div_rem[scrs_pkg::CIDX_W-1:0];
      end
      if (cmd.emit && !rep) begin
        bytes_left    <= bytes_left_next;
        pieces_sent   <= pieces_sent + PCW'(1);
        cur_in_offset <= '0;
        if (chunk_inc >= cfg.dcnt) begin
          cur_chunk  <= '0;
          cur_stripe <= cur_stripe + AW'(1);
        end else begin
          cur_chunk <= chunk_inc[scrs_pkg::CIDX_W-1:0];
        end
      end else if (cmd.emit) begin
        bytes_left <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      user  <= in_user;
      start <= in_start[AW-1:0];
      rep   <= cfg.rep;
    end
    if (cmd.emit) begin
      piece_user <= user;
      if (rep) begin
        stripe_index <= '0;
        chunk_index  <= '0;
        piece_offset <= scrs_pkg::ADDR_W'(start);
        piece_length <= bytes_left;
        last_piece   <= 1'b1;
        truncated    <= 1'b0;
      end else begin
        stripe_index <= scrs_pkg::ADDR_W'(cur_stripe);
        chunk_index  <= cur_chunk;
        piece_offset <= scrs_pkg::ADDR_W'(cur_in_offset);
        piece_length <= plen;
        last_piece   <= walk_last;
        truncated    <= at_limit && (bytes_left_next != '0);
      end
    end
  end

endmodule

>>> sv/scrs_ctrl.sv
// scrs_ctrl: splitter controller - sequences capture, the two divisions (striping mode only) and the piece walk.
// Depends on scrs_pkg.
module scrs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  scrs_pkg::stat_t stat,
  output scrs_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    IDLE,
    DIV_CHUNK,
    DIV_STRIPE,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.len_zero) begin
            state_next = IDLE;
          end else if (stat.rep) begin
            state_next = EMIT;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = DIV_CHUNK;
          end
        end
      end
      DIV_CHUNK: begin
        if (stat.div_done) begin
          cmd.take_off  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = DIV_STRIPE;
        end
      end
      DIV_STRIPE: begin
        if (stat.div_done) begin
          cmd.take_stripe = 1'b1;
          state_next      = EMIT;
        end
      end
      EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/stripe_chunk_range_splitter.sv
// Striped byte-range splitter: one request (user, offset, length) in, its chunk pieces out.
// A request in striping mode first runs two serial divisions on the shared restoring divider
// (offset by chunk size, then the chunk number by data chunks), each over OFFSET_BITS bits
// with OFFSET_BITS capped at 48; after the second division comes the piece walk, which
// emits one piece per cycle while the output side takes them, up to MAX_PIECES pieces, and
// the block takes the next request the cycle after the last piece is registered. A
// replication-mode request skips the divisions and emits its single piece once the output
// register is free; a zero-length request is taken and emits nothing. Depends on scrs_pkg,
// scrs_ctrl, scrs_dp and scrs_div.
module stripe_chunk_range_splitter #(
  parameter int MAX_PIECES  = 64,
  parameter int OFFSET_BITS = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // user_tag[31:0], start_offset[79:32], byte_length[111:80]
  input  logic [scrs_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // piece_user[31:0], stripe_index[79:32], chunk_index[83:80], piece_offset[131:84],
  // piece_length[163:132], zero[167:164]
  output logic [scrs_pkg::OUT_W-1:0]     m_axis_tdata,
  output logic                           m_axis_tlast,
  // truncated[0]
  output logic [0:0]                     m_axis_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scrs_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic                          replicate_mode;
  logic [scrs_pkg::CHUNK_W-1:0]  chunk_bytes;
  logic [scrs_pkg::DCNT_W-1:0]   data_chunks;
  scrs_pkg::cfg_t                cfg;
  scrs_pkg::cmd_t                cmd;
  scrs_pkg::stat_t               stat;
  logic                          cfg_wr;
  logic [scrs_pkg::ADDR_W-1:0]   stripe_index;
  logic [scrs_pkg::CIDX_W-1:0]   chunk_index;
  logic [scrs_pkg::ADDR_W-1:0]   piece_offset;
  logic [scrs_pkg::LEN_W-1:0]    piece_length;
  logic [scrs_pkg::USER_W-1:0]   piece_user;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      replicate_mode <= 1'b0;
      chunk_bytes    <= 32'd1048576;
      data_chunks    <= 5'd4;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        scrs_pkg::REG_MODE:  replicate_mode <= pwdata[0];
        scrs_pkg::REG_CHUNK: chunk_bytes    <= pwdata;
        scrs_pkg::REG_DCNT:  data_chunks    <= pwdata[scrs_pkg::DCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      scrs_pkg::REG_MODE:  prdata = {31'd0, replicate_mode};
      scrs_pkg::REG_CHUNK: prdata = chunk_bytes;
      scrs_pkg::REG_DCNT:  prdata = {27'd0, data_chunks};
      default:             prdata = '0;
    endcase
  end

  // zero chunk size acts as 1; data chunk count clamps to 1..16
  assign cfg.rep   = replicate_mode;
  assign cfg.csize = (chunk_bytes == '0) ? scrs_pkg::CHUNK_W'(1) : chunk_bytes;
  assign cfg.dcnt  = (data_chunks == '0) ? scrs_pkg::DCNT_W'(1) :
                     (data_chunks > scrs_pkg::DCNT_W'(16)) ? scrs_pkg::DCNT_W'(16) :
                     data_chunks;

  scrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  scrs_dp #(
    .MAX_PIECES  (MAX_PIECES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg          (cfg),
    .in_user      (s_axis_tdata[31:0]),
    .in_start     (s_axis_tdata[79:32]),
    .in_len       (s_axis_tdata[111:80]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .piece_user   (piece_user),
    .stripe_index (stripe_index),
    .chunk_index  (chunk_index),
    .piece_offset (piece_offset),
    .piece_length (piece_length),
    .last_piece   (m_axis_tlast),
    .truncated    (m_axis_tuser[0])
  );

  assign m_axis_tdata = {4'd0, piece_length, piece_offset, chunk_index, stripe_index,
                         piece_user};

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[111:80] != '0) |=> !s_axis_tready)
    else $error("splitter still ready after taking a nonzero request");

  a_trunc_on_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("truncated piece is not the last piece");

  a_chunk_in_stripe: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ({1'b0, chunk_index} < cfg.dcnt))
    else $error("chunk index beyond data chunk count");

  a_piece_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (piece_length != '0))
    else $error("empty piece emitted");

endmodule
